// ===== hdl/plccm_pkg.sv =====
// ----------------------------------------------------------------------------
// plccm_pkg: shared types and constants of the piecewise linear CC mapper
// Field widths, mode codes and the input and result beat layouts.
// ----------------------------------------------------------------------------
package plccm_pkg;
	localparam int NUM_CC = 128;
	localparam int IDX_W = 7;
	localparam int LVL_W = 32;
	localparam int SEG_W = 40;

	localparam logic [2:0] MODE_SET    = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_MOVE   = 3'd2;
	localparam logic [2:0] MODE_CHANGE = 3'd3;
	localparam logic [2:0] MODE_COMMIT = 3'd4;
	localparam logic [2:0] MODE_MAP    = 3'd5;

	typedef struct packed {
		logic [2:0]              mode;
		logic [IDX_W-1:0]        cc_index;
		logic [IDX_W-1:0]        new_cc_index;
		logic signed [LVL_W-1:0] point_value;
	} in_beat_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] mapped_value;
		logic                    map_valid;
		logic                    status;
	} out_beat_t;
endpackage

// ===== hdl/plccm_in_if.sv =====
// ----------------------------------------------------------------------------
// plccm_in_if: input item channel
// Valid/ready channel carrying one edit, commit or map item.
// ----------------------------------------------------------------------------
interface plccm_in_if;
	logic valid;
	logic ready;
	plccm_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/plccm_out_if.sv =====
// ----------------------------------------------------------------------------
// plccm_out_if: result channel
// Valid/ready channel carrying one result per item.
// ----------------------------------------------------------------------------
interface plccm_out_if;
	logic valid;
	logic ready;
	plccm_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/plccm_ram.sv =====
// ----------------------------------------------------------------------------
// plccm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module plccm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/piecewise_linear_cc_mapper.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_cc_mapper: breakpoint table with linear interpolation
// Stores breakpoints per controller index, builds segments on commit and
// maps indexes through the committed segments.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (valid/ready), one result beat leaves on
// out_ch per item. ready is low while an item is worked on and while its
// result waits, so one item is in the block at a time.
// Set/remove/change pass through the read and edit states, and move adds
// a write state; map with no valid map and commit with a missing end
// point go straight to the result. Map searches downward over segment
// starts, one index per cycle, then does a 40x8 multiply. Commit walks
// the 128 indexes, reads each present point, and runs the shared
// restoring divider twice per segment (two divisions of 48 steps each).
// After each result beat is taken the block returns to idle, where the
// next item is accepted.
// The divider takes one step per cycle.
// Reset clears the presence and segment-start bits; levels, slopes and
// offsets are undefined until written. A stalled receiver holds the result
// beat and keeps ready low.
// ----------------------------------------------------------------------------
module piecewise_linear_cc_mapper (
	input logic clk,
	input logic arst_n,
	plccm_in_if.sink in_ch,
	plccm_out_if.source out_ch
);
	localparam int IW = plccm_pkg::IDX_W;
	localparam int SW = plccm_pkg::SEG_W;
	localparam int LW = plccm_pkg::LVL_W;
	localparam int DW = 48;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_EDIT  = 4'd2;
	localparam logic [3:0] ST_MVWR  = 4'd3;
	localparam logic [3:0] ST_CWALK = 4'd4;
	localparam logic [3:0] ST_CRD   = 4'd5;
	localparam logic [3:0] ST_CDIV  = 4'd6;
	localparam logic [3:0] ST_CWR   = 4'd7;
	localparam logic [3:0] ST_MSRCH = 4'd8;
	localparam logic [3:0] ST_MRD   = 4'd9;
	localparam logic [3:0] ST_MMUL  = 4'd10;
	localparam logic [3:0] ST_MSUM  = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;
	localparam logic [3:0] ST_CRD2  = 4'd13;

	logic [3:0] state_q;
	plccm_pkg::in_beat_t item_q;
	plccm_pkg::out_beat_t res_q;
	logic [plccm_pkg::NUM_CC-1:0] pres_q, seg_q;

	logic [IW-1:0] idx_q, prev_q;
	logic have_prev_q, div_sel_q;
	logic signed [LW-1:0] y1_q, y2_q;
	logic signed [SW-1:0] slope_q;

	// divider: |num| / den, one bit per cycle
	logic [DW-1:0] quo_q, rem_q;
	logic [IW:0] den_q;
	logic [5:0] dcnt_q;
	logic neg_q;

	logic signed [SW+IW+1:0] prod_q;

	// RAM ports
	logic lv_we, sl_we;
	logic [IW-1:0] lv_addr, sl_addr;
	logic [LW-1:0] lv_wd, lv_rd;
	logic [2*SW-1:0] sl_wd, sl_rd;

	plccm_ram #(.WIDTH(LW), .DEPTH(plccm_pkg::NUM_CC)) u_lvl (
		.clk(clk), .we(lv_we), .addr(lv_addr), .wdata(lv_wd), .rdata(lv_rd));
	plccm_ram #(.WIDTH(2*SW), .DEPTH(plccm_pkg::NUM_CC)) u_seg (
		.clk(clk), .we(sl_we), .addr(sl_addr), .wdata(sl_wd), .rdata(sl_rd));

	logic cc_hit;
	assign cc_hit = pres_q[item_q.cc_index];

	// numerators, exact
	logic signed [DW-1:0] num_slope, num_off;
	logic [IW:0] dx;
	assign dx = {1'b0, idx_q} - {1'b0, prev_q};
	assign num_slope = DW'($signed(lv_rd)) - DW'(y1_q);
	assign num_off = DW'(y1_q) * $signed({1'b0, idx_q})
		- $signed({1'b0, prev_q}) * DW'(y2_q);

	logic [DW:0] trial;
	assign trial = {rem_q[DW-1:0], quo_q[DW-1]} - {{(DW-IW){1'b0}}, den_q};

	logic signed [DW:0] sq;
	logic signed [SW-1:0] sat_q;
	assign sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	always_comb begin
		if (sq > $signed((DW+1)'({1'b0, {(SW-1){1'b1}}}))) sat_q = {1'b0, {(SW-1){1'b1}}};
		else if (sq < -$signed((DW+1)'({1'b0, {(SW-1){1'b1}}})) - 1)
			sat_q = {1'b1, {(SW-1){1'b0}}};
		else sat_q = SW'(sq);
	end

	logic signed [SW+IW+2:0] sum;
	assign sum = (SW+IW+3)'(prod_q) + (SW+IW+3)'($signed(sl_rd[SW-1:0]));
	logic signed [LW-1:0] sum_sat;
	always_comb begin
		if (sum > (SW+IW+3)'(32'sh7fffffff)) sum_sat = 32'sh7fffffff;
		else if (sum < -(SW+IW+3)'(32'sh7fffffff) - 1) sum_sat = 32'sh80000000;
		else sum_sat = LW'(sum);
	end

	always_comb begin
		lv_we = 1'b0;
		lv_addr = item_q.cc_index;
		lv_wd = item_q.point_value;
		sl_we = 1'b0;
		sl_addr = idx_q;
		sl_wd = {slope_q, sat_q};
		case (state_q)
			ST_EDIT: lv_we = (item_q.mode == plccm_pkg::MODE_SET) ||
				(item_q.mode == plccm_pkg::MODE_CHANGE && cc_hit);
			ST_MVWR: begin
				lv_we = 1'b1;
				lv_addr = item_q.new_cc_index;
				lv_wd = lv_rd;
			end
			ST_CRD: lv_addr = idx_q;
			ST_CRD2: lv_addr = idx_q;
			ST_CWR: begin
				sl_we = 1'b1;
				sl_addr = prev_q;
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pres_q <= '0;
			seg_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					item_q <= in_ch.data;
					res_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					res_q.map_valid <= (item_q.mode == plccm_pkg::MODE_COMMIT)
						? 1'b0 : seg_q[0];
					idx_q <= (item_q.mode == plccm_pkg::MODE_MAP) ? item_q.cc_index : '0;
					have_prev_q <= 1'b0;
					case (item_q.mode)
						plccm_pkg::MODE_COMMIT: begin
							seg_q <= '0;
							state_q <= (pres_q[0] && pres_q[plccm_pkg::NUM_CC-1])
								? ST_CWALK : ST_OUT;
						end
						plccm_pkg::MODE_MAP: begin
							state_q <= seg_q[0] ? ST_MSRCH : ST_OUT;
						end
						plccm_pkg::MODE_SET, plccm_pkg::MODE_REMOVE,
						plccm_pkg::MODE_MOVE, plccm_pkg::MODE_CHANGE: state_q <= ST_EDIT;
						default: state_q <= ST_OUT;
					endcase
				end
				ST_EDIT: begin
					case (item_q.mode)
						plccm_pkg::MODE_SET: begin
							pres_q[item_q.cc_index] <= 1'b1;
							state_q <= ST_OUT;
						end
						plccm_pkg::MODE_REMOVE: begin
							res_q.status <= !cc_hit;
							pres_q[item_q.cc_index] <= 1'b0;
							state_q <= ST_OUT;
						end
						plccm_pkg::MODE_CHANGE: begin
							res_q.status <= !cc_hit;
							state_q <= ST_OUT;
						end
						plccm_pkg::MODE_MOVE: begin
							res_q.status <= !cc_hit;
							if (cc_hit && item_q.new_cc_index != item_q.cc_index)
								state_q <= ST_MVWR;
							else state_q <= ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_MVWR: begin
					pres_q[item_q.new_cc_index] <= 1'b1;
					pres_q[item_q.cc_index] <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_CWALK: begin
					if (pres_q[idx_q]) state_q <= ST_CRD;
					else if (idx_q == IW'(plccm_pkg::NUM_CC-1)) begin
						res_q.map_valid <= seg_q[0];
						state_q <= ST_OUT;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_CRD: state_q <= ST_CRD2;
				ST_CRD2: begin
					y2_q <= lv_rd;
					if (have_prev_q) begin
						div_sel_q <= 1'b0;
						state_q <= ST_CDIV;
						dcnt_q <= '0;
						den_q <= dx;
						neg_q <= num_slope[DW-1];
						quo_q <= num_slope[DW-1] ? -num_slope : num_slope;
						rem_q <= '0;
					end else begin
						have_prev_q <= 1'b1;
						prev_q <= idx_q;
						y1_q <= lv_rd;
						idx_q <= idx_q + 1'b1;
						state_q <= ST_CWALK;
					end
				end
				ST_CDIV: begin
					if (trial[DW]) begin
						rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end else begin
						rem_q <= trial[DW-1:0];
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(DW-1)) state_q <= ST_CWR;
				end
				ST_CWR: begin
					if (!div_sel_q) begin
						slope_q <= sat_q;
						div_sel_q <= 1'b1;
						dcnt_q <= '0;
						neg_q <= num_off[DW-1];
						quo_q <= num_off[DW-1] ? -num_off : num_off;
						rem_q <= '0;
						state_q <= ST_CDIV;
					end else begin
						seg_q[prev_q] <= 1'b1;
						prev_q <= idx_q;
						y1_q <= y2_q;
						if (idx_q == IW'(plccm_pkg::NUM_CC-1)) begin
							res_q.map_valid <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_CWALK;
						end
					end
				end
				ST_MSRCH: begin
					if (idx_q == '0 || seg_q[idx_q]) state_q <= ST_MRD;
					else idx_q <= idx_q - 1'b1;
				end
				ST_MRD: state_q <= ST_MMUL;
				ST_MMUL: begin
					prod_q <= $signed(sl_rd[2*SW-1:SW]) * $signed({1'b0, item_q.cc_index});
					state_q <= ST_MSUM;
				end
				ST_MSUM: begin
					res_q.mapped_value <= sum_sat;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
